// ===== src/keyboard_matrix_scanner_top_defines.svh =====
// assertion macros shared by the keyboard matrix scanner rtl
`ifndef KEYBOARD_MATRIX_SCANNER_TOP_DEFINES_SVH
`define KEYBOARD_MATRIX_SCANNER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define KMS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define KMS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/kms_pkg.sv =====
// shared types and constants of the keyboard matrix scanner
`default_nettype none

package kms_pkg;

   localparam int TIME_W     = 32;
   localparam int CSR_DATA_W = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int INTERVAL_W = 10;
   localparam int REPEAT_W   = 12;
   localparam int ROW_W      = 3;
   localparam int COLF_W     = 4;
   localparam int LAYER_W    = 2;
   localparam int PEND_W     = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_AUTO_POLL     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCAN_INTERVAL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_DELAY  = 2'd2;

   localparam logic [INTERVAL_W-1:0] SCAN_INTERVAL_RESET = 10'd50;
   localparam logic [REPEAT_W-1:0]   REPEAT_DELAY_RESET  = 12'd300;

   localparam logic [LAYER_W-1:0] LAYER_REGULAR = 2'd0;
   localparam logic [LAYER_W-1:0] LAYER_SHIFT   = 2'd1;
   localparam logic [LAYER_W-1:0] LAYER_SYMBOLS = 2'd2;
   localparam logic [LAYER_W-1:0] LAYER_NUMBERS = 2'd3;

   localparam logic OP_POLL = 1'b0;
   localparam logic OP_READ = 1'b1;

   // queued key code, layer in the top bits
   typedef struct packed {
      logic [LAYER_W-1:0] layer;
      logic [ROW_W-1:0]   row;
      logic [COLF_W-1:0]  col;
   } kms_code_type;

   typedef struct packed {
      logic push;
      logic pop;
   } kms_fifo_ctrl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } kms_fifo_stat_type;

endpackage

`default_nettype wire

// ===== src/kms_row_lane.sv =====
// one row lane: flags whether any key of its row is pressed
`default_nettype none

module kms_row_lane #(
   parameter int COLS = 9
) (
   input  wire logic [COLS-1:0] row_bits,
   output logic                 row_any
);

   assign row_any = |row_bits;

endmodule

`default_nettype wire

// ===== src/kms_merge.sv =====
// merge of the row lanes: picks the first row with a pressed key
`default_nettype none

module kms_merge #(
   parameter int ROWS = 5,
   parameter int COLS = 9
) (
   input  wire logic [ROWS-1:0]      row_any,
   input  wire logic [ROWS*COLS-1:0] matrix,
   output logic                      sel_found,
   output logic [kms_pkg::ROW_W-1:0] sel_row,
   output logic [COLS-1:0]           sel_bits
);

   import kms_pkg::*;

   // lowest row wins: scan from the top down, last hit stands
   always_comb begin
      sel_row = '0;
      for (int r = ROWS - 1; r >= 0; r--) begin
         if (row_any[r]) begin
            sel_row = ROW_W'(r);
         end
      end
   end

   assign sel_found = |row_any;
   assign sel_bits  = matrix[sel_row * COLS +: COLS];

endmodule

`default_nettype wire

// ===== src/kms_fifo.sv =====
// key code queue: circular buffer in a memory with registered read
`default_nettype none

module kms_fifo #(
   parameter int FIFO_DEPTH = 16,
   parameter int CNT_W      = 5
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire kms_pkg::kms_fifo_ctrl_type ctrl,
   input  wire kms_pkg::kms_code_type      wr_code,
   output kms_pkg::kms_code_type           rd_code,
   output kms_pkg::kms_fifo_stat_type      stat,
   output logic [CNT_W-1:0]                count
);

   import kms_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(FIFO_DEPTH - 1);

   kms_code_type     key_mem_ff [FIFO_DEPTH];
   kms_code_type     rd_code_ff;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (ctrl.push) begin
         tail_in = (tail_ff == LAST_PTR) ? '0 : tail_ff + 1'b1;
      end
      if (ctrl.pop) begin
         head_in = (head_ff == LAST_PTR) ? '0 : head_ff + 1'b1;
      end
      if (ctrl.push && !ctrl.pop) begin
         count_in = count_ff + 1'b1;
      end else if (ctrl.pop && !ctrl.push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         key_mem_ff[tail_ff] <= wr_code;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.pop) begin
         rd_code_ff <= key_mem_ff[head_ff];
      end
   end

   assign rd_code    = rd_code_ff;
   assign count      = count_ff;
   assign stat.full  = (count_ff == CNT_W'(FIFO_DEPTH));
   assign stat.empty = (count_ff == '0);

endmodule

`default_nettype wire

// ===== src/keyboard_matrix_scanner_top.sv =====
// top level of the keyboard matrix scanner with sticky modifier keys
//
//  channel  dir  handshake               payload
//  req      in   req_tvalid/req_tready   tuser op, tdata now_ms, key_matrix
//  rsp      out  rsp_tvalid/rsp_tready   tuser key_valid, tdata code and status
//  csr      in   csr_valid/csr_ready     csr_index, csr_data (always ready)
//
//  an item goes through accept into the hold register, evaluate, pop, result
//  a poll that queues keys adds a column walk, one column of the picked row per
//  cycle through the single write port of the queue memory
//  the next transaction is taken in the cycle the result moves to the output
//  register; a stalled rsp side holds one result there and one more finished
//  result in the sequencer, and req_tready stays low until the output frees
//  reset is synchronous, active high; the queue memory needs no clearing
`default_nettype none
`include "keyboard_matrix_scanner_top_defines.svh"

module keyboard_matrix_scanner_top #(
   parameter int FIFO_DEPTH = 16,
   parameter int ROWS       = 5,
   parameter int COLS       = 9,
   localparam int MAT_W     = ROWS * COLS,
   localparam int REQ_W     = ((kms_pkg::TIME_W + MAT_W + 7) / 8) * 8
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // input transaction
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [REQ_W-1:0]               req_tdata,  // now_ms, key_matrix, zero fill
   input  wire logic                           req_tuser,  // op
   // result transaction
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [15:0]                         rsp_tdata,  // key_layer, key_row, key_col,
                                                           // pending, dropped, scanned
   output logic                                rsp_tuser,  // key_valid
   // register writes
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [kms_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [kms_pkg::CSR_DATA_W-1:0] csr_data
);

   import kms_pkg::*;

   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam int COL_W = (COLS > 1) ? $clog2(COLS) : 1;
   localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLS - 1);

   // sequencer codes
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_PUSH = 2'd1;
   localparam logic [1:0] S_POP  = 2'd2;
   localparam logic [1:0] S_FIN  = 2'd3;

   // configuration
   logic                  auto_poll_ff;
   logic [INTERVAL_W-1:0] interval_ff;
   logic [REPEAT_W-1:0]   repeat_ff;

   // hold register: the transaction under work
   logic              hold_valid_ff, hold_valid_in;
   logic              hold_op_ff;
   logic [TIME_W-1:0] hold_now_ff;
   logic [MAT_W-1:0]  hold_mat_ff;

   // scan state
   logic [TIME_W-1:0] last_ff, last_in;
   logic              has_scanned_ff, has_scanned_in;
   logic              released_ff, released_in;
   logic              shift_ff, shift_in;
   logic              numbers_ff, numbers_in;
   logic              symbols_ff, symbols_in;

   // per-item work registers
   logic [1:0]         state_ff, state_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [COLS-1:0]    row_bits_ff, row_bits_in;
   logic [ROW_W-1:0]   row_idx_ff, row_idx_in;
   logic [LAYER_W-1:0] layer_ff, layer_in;
   logic               scanned_ff, scanned_in;
   logic               lost_ff, lost_in;
   logic               popped_ff, popped_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_data_ff, rsp_data_in;
   logic        rsp_user_ff, rsp_user_in;

   // lanes and merge
   logic [ROWS-1:0]  row_any;
   logic             sel_found;
   logic [ROW_W-1:0] sel_row;
   logic [COLS-1:0]  sel_bits;

   // queue
   kms_fifo_ctrl_type fifo_ctrl;
   kms_fifo_stat_type fifo_stat;
   kms_code_type      wr_code, rd_code, out_code;
   logic [CNT_W-1:0]  fifo_count;

   // evaluation terms
   logic              key_shift, key_numbers, key_symbols, tog_any;
   logic              do_poll, too_soon, over_repeat, do_scan;
   logic [TIME_W-1:0] elapsed;
   logic              push_bit, fin_go;
   logic [LAYER_W-1:0] cur_layer;

   // register port, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         auto_poll_ff <= 1'b0;
         interval_ff  <= SCAN_INTERVAL_RESET;
         repeat_ff    <= REPEAT_DELAY_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_AUTO_POLL:     auto_poll_ff <= csr_data[0];
            CSR_SCAN_INTERVAL: interval_ff  <= csr_data[INTERVAL_W-1:0];
            CSR_REPEAT_DELAY:  repeat_ff    <= csr_data[REPEAT_W-1:0];
            default:           ;  // unmapped index, write is dropped
         endcase
      end
   end

   // one lane per matrix row
   for (genvar r = 0; r < ROWS; r++) begin : g_lane
      kms_row_lane #(
         .COLS(COLS)
      ) u_lane (
         .row_bits(hold_mat_ff[r*COLS +: COLS]),
         .row_any (row_any[r])
      );
   end

   kms_merge #(
      .ROWS(ROWS),
      .COLS(COLS)
   ) u_merge (
      .row_any  (row_any),
      .matrix   (hold_mat_ff),
      .sel_found(sel_found),
      .sel_row  (sel_row),
      .sel_bits (sel_bits)
   );

   // sticky toggle keys; a key outside a small matrix reads as released
   if (ROWS > 1 && COLS > 1) begin : g_shift
      assign key_shift = hold_mat_ff[COLS + 1];
   end else begin : g_no_shift
      assign key_shift = 1'b0;
   end
   if (COLS > 2) begin : g_numbers
      assign key_numbers = hold_mat_ff[2];
   end else begin : g_no_numbers
      assign key_numbers = 1'b0;
   end
   if (COLS > 3) begin : g_symbols
      assign key_symbols = hold_mat_ff[3];
   end else begin : g_no_symbols
      assign key_symbols = 1'b0;
   end
   assign tog_any = key_shift | key_numbers | key_symbols;

   // numbers beats symbols, symbols beats shift
   assign cur_layer = numbers_ff ? LAYER_NUMBERS :
                      symbols_ff ? LAYER_SYMBOLS :
                      shift_ff   ? LAYER_SHIFT   : LAYER_REGULAR;

   // poll gating, elapsed time wraps modulo 2^32
   assign do_poll     = (hold_op_ff == OP_POLL) || auto_poll_ff;
   assign elapsed     = hold_now_ff - last_ff;
   assign too_soon    = elapsed < TIME_W'(interval_ff);
   assign over_repeat = elapsed > TIME_W'(repeat_ff);
   assign do_scan     = do_poll && (!has_scanned_ff || (!too_soon && released_ff));

   assign push_bit = row_bits_ff[col_ff];
   assign fin_go   = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_tready);

   assign wr_code.layer = layer_ff;
   assign wr_code.row   = row_idx_ff;
   assign wr_code.col   = COLF_W'(col_ff);

   assign fifo_ctrl.push = (state_ff == S_PUSH) && push_bit && !fifo_stat.full;
   assign fifo_ctrl.pop  = (state_ff == S_POP) && (hold_op_ff == OP_READ) &&
                           !fifo_stat.empty;

   kms_fifo #(
      .FIFO_DEPTH(FIFO_DEPTH),
      .CNT_W     (CNT_W)
   ) u_fifo (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (fifo_ctrl),
      .wr_code(wr_code),
      .rd_code(rd_code),
      .stat   (fifo_stat),
      .count  (fifo_count)
   );

   // a new transaction is taken when the hold register is empty or frees now
   assign req_tready = !hold_valid_ff || fin_go;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (fin_go) begin
         hold_valid_in = 1'b0;
      end
      if (req_tvalid && req_tready) begin
         hold_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         hold_op_ff  <= req_tuser;
         hold_now_ff <= req_tdata[TIME_W-1:0];
         hold_mat_ff <= req_tdata[TIME_W +: MAT_W];
      end
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      col_in         = col_ff;
      row_bits_in    = row_bits_ff;
      row_idx_in     = row_idx_ff;
      layer_in       = layer_ff;
      scanned_in     = scanned_ff;
      lost_in        = lost_ff;
      popped_in      = popped_ff;
      last_in        = last_ff;
      has_scanned_in = has_scanned_ff;
      released_in    = released_ff;
      shift_in       = shift_ff;
      numbers_in     = numbers_ff;
      symbols_in     = symbols_ff;
      case (state_ff)
         S_IDLE: begin
            if (hold_valid_ff) begin
               scanned_in  = do_scan;
               lost_in     = 1'b0;
               popped_in   = 1'b0;
               col_in      = '0;
               row_bits_in = sel_bits;
               row_idx_in  = sel_row;
               layer_in    = cur_layer;
               state_in    = S_POP;
               if (do_scan) begin
                  has_scanned_in = 1'b1;
                  last_in        = hold_now_ff;
                  if (tog_any) begin
                     // toggle keys flip and nothing is queued
                     shift_in    = shift_ff ^ key_shift;
                     numbers_in  = numbers_ff ^ key_numbers;
                     symbols_in  = symbols_ff ^ key_symbols;
                     released_in = 1'b0;
                  end else if (sel_found) begin
                     shift_in    = 1'b0;
                     numbers_in  = 1'b0;
                     symbols_in  = 1'b0;
                     released_in = 1'b0;
                     state_in    = S_PUSH;
                  end else begin
                     released_in = 1'b1;
                  end
               end else if (do_poll && has_scanned_ff && !too_soon) begin
                  // held key: wait out the repeat delay
                  released_in = over_repeat;
               end
            end
         end
         S_PUSH: begin
            if (push_bit && fifo_stat.full) begin
               lost_in = 1'b1;
            end
            col_in = col_ff + 1'b1;
            if (col_ff == LAST_COL) begin
               state_in = S_POP;
            end
         end
         S_POP: begin
            popped_in = fifo_ctrl.pop;
            state_in  = S_FIN;
         end
         S_FIN: begin
            if (fin_go) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         hold_valid_ff  <= 1'b0;
         last_ff        <= '0;
         has_scanned_ff <= 1'b0;
         released_ff    <= 1'b1;
         shift_ff       <= 1'b0;
         numbers_ff     <= 1'b0;
         symbols_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         hold_valid_ff  <= hold_valid_in;
         last_ff        <= last_in;
         has_scanned_ff <= has_scanned_in;
         released_ff    <= released_in;
         shift_ff       <= shift_in;
         numbers_ff     <= numbers_in;
         symbols_ff     <= symbols_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff      <= col_in;
      row_bits_ff <= row_bits_in;
      row_idx_ff  <= row_idx_in;
      layer_ff    <= layer_in;
      scanned_ff  <= scanned_in;
      lost_ff     <= lost_in;
      popped_ff   <= popped_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   // output register, loaded when the result is finished and the slot is free
   assign out_code = popped_ff ? rd_code : '0;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (fin_go) begin
         rsp_valid_in = 1'b1;
         rsp_user_in  = popped_ff;
         rsp_data_in  = {scanned_ff, lost_ff, PEND_W'(fifo_count), out_code.col,
                         out_code.row, out_code.layer};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // checks
   `KMS_ASSERT_IMPL(a_busy_has_item, clock, reset, state_ff != S_IDLE, hold_valid_ff,
      "sequencer busy without a held transaction")
   `KMS_ASSERT_NEXT(a_fin_loads_out, clock, reset, fin_go, rsp_valid_ff,
      "finished result did not reach the output register")
   `KMS_ASSERT_NEXT(a_full_drops, clock, reset,
      (state_ff == S_PUSH) && push_bit && fifo_stat.full, lost_ff,
      "push into a full queue not flagged as dropped")
   `KMS_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, fifo_count <= CNT_W'(FIFO_DEPTH),
      "queue count above depth")

endmodule

`default_nettype wire
